>>> hw/rtl/linked_buffer_queue_manager_assert.svh
// Assertion helpers for the queue manager RTL.
// Each macro expects clk and arst_n to be in scope.
`ifndef LINKED_BUFFER_QUEUE_MANAGER_ASSERT_SVH
`define LINKED_BUFFER_QUEUE_MANAGER_ASSERT_SVH

// Same-cycle implication.
`define LBQM_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbqm check failed");

// Next-cycle implication.
`define LBQM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbqm check failed");

`endif

>>> hw/rtl/lbqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqm_pkg
// Shared constants, types and helpers of the linked buffer queue manager.
// ----------------------------------------------------------------------------
package lbqm_pkg;

	localparam int NUM_BUFFERS = 256;
	localparam int ID_W        = 8;
	localparam int AW          = $clog2(NUM_BUFFERS);
	localparam int PW          = $clog2(NUM_BUFFERS + 1);
	localparam int CQ_DEPTH    = 2;
	localparam int CQ_AW       = $clog2(CQ_DEPTH);
	localparam int CQ_CW       = $clog2(CQ_DEPTH + 1);

	typedef logic [PW-1:0]   ptr_t;
	typedef logic [AW-1:0]   addr_t;
	typedef logic [ID_W-1:0] id_t;

	localparam ptr_t NONE_PTR = PW'(NUM_BUFFERS);

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_DELETE  = 2'd2;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_ENQ,
		CMD_DEQ,
		CMD_DEL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		ptr_t      bid;
	} cmd_t;

	typedef struct packed {
		logic success;
		logic popped_valid;
		id_t  popped_id;
		logic queue_empty;
		id_t  head_id;
		id_t  tail_id;
	} res_t;

	function automatic id_t ptr_to_id(input ptr_t p);
		logic [PW+ID_W-1:0] wide;
		begin
			wide = {{ID_W{1'b0}}, p};
			return wide[ID_W-1:0];
		end
	endfunction

	function automatic logic id_in_range(input id_t id);
		logic [PW+ID_W-1:0] wide;
		begin
			wide = {{PW{1'b0}}, id};
			return wide < (PW + ID_W)'(NUM_BUFFERS);
		end
	endfunction

	function automatic ptr_t id_to_ptr(input id_t id);
		logic [PW+ID_W-1:0] wide;
		begin
			wide = {{PW{1'b0}}, id};
			return wide[PW-1:0];
		end
	endfunction

endpackage

>>> hw/rtl/linked_buffer_queue_manager.sv
`timescale 1ns / 1ps
// Enqueue, dequeue and delete of the head pass the front register, command FIFO, idle state with
// its link table read, enqueue or pop state and result register. Delete of another buffer walks
// the link table one link per cycle from the head, then unlinks a tail buffer, bridges and clears
// a middle one, or ends at the list end. The engine takes no new command until the last one's
// link table read and write are done. Reset: head and tail go to none; a clearing pass then
// writes none into every link table entry with in_ready low.
// ----------------------------------------------------------------------------
// linked_buffer_queue_manager
// FIFO of buffer numbers kept as a linked list, with enqueue, dequeue and delete.
// ----------------------------------------------------------------------------
module linked_buffer_queue_manager import lbqm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] buffer_id,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       success,
	output logic       popped_valid,
	output logic [7:0] popped_id,
	output logic       queue_empty,
	output logic [7:0] head_id,
	output logic [7:0] tail_id
);

	logic init_done;
	logic fe_valid;
	logic fe_ready;
	cmd_t fe_cmd;
	logic cq_valid;
	logic cq_ready;
	cmd_t cq_cmd;
	res_t res;

	lbqm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (init_done),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.buffer_id (buffer_id),
		.cmd_valid (fe_valid),
		.cmd       (fe_cmd),
		.cmd_ready (fe_ready)
	);

	lbqm_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_cmd   (fe_cmd),
		.pop_valid  (cq_valid),
		.pop_ready  (cq_ready),
		.pop_cmd    (cq_cmd)
	);

	lbqm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.init_done (init_done),
		.cmd_valid (cq_valid),
		.cmd_ready (cq_ready),
		.cmd       (cq_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign success      = res.success;
	assign popped_valid = res.popped_valid;
	assign popped_id    = res.popped_id;
	assign queue_empty  = res.queue_empty;
	assign head_id      = res.head_id;
	assign tail_id      = res.tail_id;

endmodule

>>> hw/rtl/lbqm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqm_front
// Input stage: takes an item, decodes it into a command and hands it on.
// ----------------------------------------------------------------------------
module lbqm_front import lbqm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       enable,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  id_t        buffer_id,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_ready
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_dec;
	logic take;

	always_comb begin
		cmd_dec.bid  = id_to_ptr(buffer_id);
		cmd_dec.kind = CMD_NOP;
		unique case (operation)
			OP_ENQUEUE: cmd_dec.kind = id_in_range(buffer_id) ? CMD_ENQ : CMD_NOP;
			OP_DEQUEUE: cmd_dec.kind = CMD_DEQ;
			OP_DELETE:  cmd_dec.kind = id_in_range(buffer_id) ? CMD_DEL : CMD_NOP;
			default:    cmd_dec.kind = CMD_NOP;
		endcase
	end

	assign in_ready  = enable && (!valid_s1 || cmd_ready);
	assign take      = in_valid && in_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				cmd_s1   <= cmd_dec;
			end else if (cmd_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/lbqm_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqm_cmd_fifo
// Short command queue between the decode front and the list engine.
// ----------------------------------------------------------------------------
module lbqm_cmd_fifo import lbqm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t             slot_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CQ_CW'(CQ_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/lbqm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbqm_back
// List engine: link table, head and tail, command sequencer, result register.
// ----------------------------------------------------------------------------
`include "linked_buffer_queue_manager_assert.svh"

module lbqm_back import lbqm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	output logic init_done,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output res_t res
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ENQ,
		ST_POP,
		ST_WALK,
		ST_DEL_NXT,
		ST_DEL_CLR
	} state_t;

	ptr_t   link_mem [NUM_BUFFERS];
	ptr_t   rdata_q;

	state_t state_q, state_d;
	cmd_t   cmd_q, cmd_d;
	ptr_t   head_q, head_d;
	ptr_t   tail_q, tail_d;
	ptr_t   prev_q, prev_d;
	addr_t  steps_q, steps_d;
	addr_t  clr_q, clr_d;
	logic   out_valid_q;
	res_t   res_q;

	logic   rd_en;
	addr_t  rd_addr;
	logic   wr_en;
	ptr_t   wr_ptr;
	ptr_t   wr_data;
	logic   fin;
	logic   ok;
	logic   popped;
	ptr_t   pid;
	logic   res_free;
	logic   imm;
	res_t   res_d;

	assign res_free  = !out_valid_q || out_ready;
	assign init_done = state_q != ST_CLEAR;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		head_d    = head_q;
		tail_d    = tail_q;
		prev_d    = prev_q;
		steps_d   = steps_q;
		clr_d     = clr_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_ptr    = '0;
		wr_data   = NONE_PTR;
		fin       = 1'b0;
		ok        = 1'b0;
		popped    = 1'b0;
		pid       = NONE_PTR;
		cmd_ready = 1'b0;
		imm       = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_ptr  = PW'(clr_q);
				clr_d   = clr_q + 1'b1;
				if (clr_q == AW'(NUM_BUFFERS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_d = cmd;
					unique case (cmd.kind)
						CMD_ENQ: begin
							cmd_ready = 1'b1;
							rd_en     = 1'b1;
							rd_addr   = cmd.bid[AW-1:0];
							state_d   = ST_ENQ;
						end
						CMD_DEQ, CMD_DEL: begin
							if (head_q == NONE_PTR) begin
								imm = 1'b1;
							end else begin
								cmd_ready = 1'b1;
								rd_en     = 1'b1;
								rd_addr   = head_q[AW-1:0];
								if (cmd.kind == CMD_DEQ || cmd.bid == head_q) begin
									state_d = ST_POP;
								end else begin
									prev_d  = head_q;
									steps_d = '0;
									state_d = ST_WALK;
								end
							end
						end
						default: imm = 1'b1;
					endcase
					// bad code, empty queue: answer at once, nothing changes
					if (imm && res_free) begin
						cmd_ready = 1'b1;
						fin       = 1'b1;
					end
				end
			end
			ST_ENQ: begin
				if (res_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
					if (rdata_q != NONE_PTR) begin
						ok = 1'b0;
					end else if (head_q == NONE_PTR) begin
						head_d = cmd_q.bid;
						tail_d = cmd_q.bid;
						ok     = 1'b1;
					end else if (tail_q == cmd_q.bid) begin
						ok = 1'b0;
					end else begin
						wr_en   = 1'b1;
						wr_ptr  = tail_q;
						wr_data = cmd_q.bid;
						tail_d  = cmd_q.bid;
						ok      = 1'b1;
					end
				end
			end
			ST_POP: begin
				if (res_free) begin
					fin     = 1'b1;
					ok      = 1'b1;
					popped  = cmd_q.kind == CMD_DEQ;
					pid     = head_q;
					head_d  = rdata_q;
					if (rdata_q == NONE_PTR) begin
						tail_d = NONE_PTR;
					end
					wr_en   = 1'b1;
					wr_ptr  = head_q;
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				// rdata_q holds the successor of prev_q
				if (rdata_q == cmd_q.bid) begin
					if (tail_q == cmd_q.bid) begin
						if (res_free) begin
							fin     = 1'b1;
							ok      = 1'b1;
							tail_d  = prev_q;
							wr_en   = 1'b1;
							wr_ptr  = prev_q;
							state_d = ST_IDLE;
						end
					end else begin
						rd_en   = 1'b1;
						rd_addr = cmd_q.bid[AW-1:0];
						state_d = ST_DEL_NXT;
					end
				end else if (rdata_q == NONE_PTR || steps_q == AW'(NUM_BUFFERS - 1)) begin
					if (res_free) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					prev_d  = rdata_q;
					steps_d = steps_q + 1'b1;
					rd_en   = 1'b1;
					rd_addr = rdata_q[AW-1:0];
				end
			end
			ST_DEL_NXT: begin
				// bridge the predecessor over the removed buffer
				wr_en   = 1'b1;
				wr_ptr  = prev_q;
				wr_data = rdata_q;
				state_d = ST_DEL_CLR;
			end
			ST_DEL_CLR: begin
				if (res_free) begin
					fin     = 1'b1;
					ok      = 1'b1;
					wr_en   = 1'b1;
					wr_ptr  = cmd_q.bid;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		res_d.success      = ok;
		res_d.popped_valid = popped;
		res_d.popped_id    = popped ? ptr_to_id(pid) : '0;
		res_d.queue_empty  = head_d == NONE_PTR;
		res_d.head_id      = (head_d == NONE_PTR) ? '0 : ptr_to_id(head_d);
		res_d.tail_id      = (tail_d == NONE_PTR) ? '0 : ptr_to_id(tail_d);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_ptr[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cmd_q       <= '0;
			head_q      <= NONE_PTR;
			tail_q      <= NONE_PTR;
			prev_q      <= NONE_PTR;
			steps_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			state_q <= state_d;
			cmd_q   <= cmd_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			prev_q  <= prev_d;
			steps_q <= steps_d;
			clr_q   <= clr_d;
			if (fin) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LBQM_ASSERT(a_head_tail_none, 1'b1, (head_q == NONE_PTR) == (tail_q == NONE_PTR))
	`LBQM_ASSERT(a_no_cmd_in_clear, state_q == ST_CLEAR, !cmd_ready && !fin)
	`LBQM_ASSERT(a_write_in_range, wr_en, wr_ptr < NONE_PTR)
	`LBQM_ASSERT(a_popped_ok, out_valid_q && res_q.popped_valid, res_q.success)
	`LBQM_ASSERT_NEXT(a_fin_shows, fin, out_valid_q)

endmodule
